[hw/rtl/ussd_pkg.sv]
// package for the unsigned shift-subtract divider: widths, state type, control bundle
`timescale 1ns / 1ps
`default_nettype none

package ussd_pkg;

    // default operand width of the divider core
    localparam int DATA_WIDTH_DEF = 32;
    // fixed width of the data ports
    localparam int FIELD_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // strobes from the sequencer to the cell row and output register
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/ussd_cell.sv]
// one bit slice of the divider: remainder, dividend/quotient and divisor bit with borrow
`timescale 1ns / 1ps
`default_nettype none

module ussd_cell (
    input  wire  logic clk,
    input  wire  logic load,
    input  wire  logic step,
    input  wire  logic op_a,
    input  wire  logic op_d,
    input  wire  logic r_in,
    input  wire  logic a_in,
    input  wire  logic borrow_in,
    input  wire  logic fits,
    output logic       r_bit,
    output logic       a_bit,
    output logic       borrow_out
);

    logic r_reg;
    logic r_next;
    logic a_reg;
    logic a_next;
    logic d_reg;
    logic d_next;
    logic diff;

    // shifted remainder bit minus divisor bit
    assign diff       = r_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~r_in & d_reg) | (~(r_in ^ d_reg) & borrow_in);

    always_comb
    begin
        r_next = r_reg;
        a_next = a_reg;
        d_next = d_reg;
        if (load)
        begin
            r_next = 1'b0;
            a_next = op_a;
            d_next = op_d;
        end
        else if (step)
        begin
            r_next = fits ? diff : r_in;
            a_next = a_in;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        d_reg <= d_next;
    end

    assign r_bit = r_reg;
    assign a_bit = a_reg;

endmodule

`default_nettype wire

[hw/rtl/ussd_ctrl.sv]
// sequencer of the divider: load, step count and hand-off to the output register
`timescale 1ns / 1ps
`default_nettype none

module ussd_ctrl #(
    parameter int DATA_WIDTH = ussd_pkg::DATA_WIDTH_DEF
) (
    input  wire  logic            clk,
    input  wire  logic            rst_n,
    input  wire  logic            in_valid,
    input  wire  logic            out_free,
    output logic                  in_ready,
    output ussd_pkg::ctrl_t       ctrl
);

    import ussd_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.capture = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.capture = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign cnt_next = ctrl.step ? cnt_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/unsigned_shift_subtract_divider.sv]
// top level of the unsigned shift-subtract divider: cell row, sequencer, output register
`timescale 1ns / 1ps
`default_nettype none

// restoring unsigned divider built as a row of DATA_WIDTH bit cells. each cell
// holds one bit of the partial remainder, one bit of the shared dividend/quotient
// register and one divisor bit; every step the row shifts left by one cell and
// a borrow ripples across the row to decide whether the divisor fits. one word
// is in flight at a time: after the word is taken there are DATA_WIDTH steps of
// the cell row, then the result moves into the output register once that
// register is free, and only then can a new word be taken. the borrow chain
// produces one quotient bit per cycle while the row steps. the output
// register lets the next word start while a result still waits. operands are
// cut to (or zero-extended to) DATA_WIDTH bits, results zero-extended or cut to
// the 32-bit ports. a zero divisor needs no special path: every trial fits, so
// the quotient comes out all ones and the remainder equals the dividend; the
// divide_by_zero flag is set alongside
module unsigned_shift_subtract_divider #(
    parameter int DATA_WIDTH = ussd_pkg::DATA_WIDTH_DEF
) (
    input  wire  logic                             clk,
    input  wire  logic                             rst_n,
    input  wire  logic                             in_valid,
    output logic                                   in_ready,
    input  wire  logic [ussd_pkg::FIELD_WIDTH-1:0] dividend,
    input  wire  logic [ussd_pkg::FIELD_WIDTH-1:0] divisor,
    output logic                                   out_valid,
    input  wire  logic                             out_ready,
    output logic [ussd_pkg::FIELD_WIDTH-1:0]       quotient,
    output logic [ussd_pkg::FIELD_WIDTH-1:0]       remainder,
    output logic                                   divide_by_zero
);

    import ussd_pkg::*;

    ctrl_t                 ctrl;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_d;
    logic [DATA_WIDTH-1:0] r_vec;
    logic [DATA_WIDTH-1:0] a_vec;
    logic [DATA_WIDTH:0]   borrow;
    logic                  fits;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FIELD_WIDTH-1:0] quot_reg;
    logic [FIELD_WIDTH-1:0] quot_next;
    logic [FIELD_WIDTH-1:0] rem_reg;
    logic [FIELD_WIDTH-1:0] rem_next;
    logic                   dz_reg;
    logic                   dz_next;
    logic                   zero_reg;
    logic                   zero_next;

    // operand width adaptation
    generate
        if (DATA_WIDTH >= FIELD_WIDTH)
        begin : g_op_wide
            assign op_a = DATA_WIDTH'(dividend);
            assign op_d = DATA_WIDTH'(divisor);
        end
        else
        begin : g_op_narrow
            assign op_a = dividend[DATA_WIDTH-1:0];
            assign op_d = divisor[DATA_WIDTH-1:0];
        end
    endgenerate

    // result width adaptation
    generate
        if (DATA_WIDTH >= FIELD_WIDTH)
        begin : g_res_wide
            assign quot_next = ctrl.capture ? a_vec[FIELD_WIDTH-1:0] : quot_reg;
            assign rem_next  = ctrl.capture ? r_vec[FIELD_WIDTH-1:0] : rem_reg;
        end
        else
        begin : g_res_narrow
            assign quot_next = ctrl.capture ? FIELD_WIDTH'(a_vec) : quot_reg;
            assign rem_next  = ctrl.capture ? FIELD_WIDTH'(r_vec) : rem_reg;
        end
    endgenerate

    ussd_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // top remainder bit shifted out acts as the carry of the trial subtract
    assign borrow[0] = 1'b0;
    assign fits      = r_vec[DATA_WIDTH-1] | ~borrow[DATA_WIDTH];

    genvar gi;
    generate
        for (gi = 0; gi < DATA_WIDTH; gi++)
        begin : g_cell
            logic r_in;
            logic a_in;
            if (gi == 0)
            begin : g_first
                // next dividend bit enters the remainder, quotient bit enters the bottom
                assign r_in = a_vec[DATA_WIDTH-1];
                assign a_in = fits;
            end
            else
            begin : g_rest
                assign r_in = r_vec[gi-1];
                assign a_in = a_vec[gi-1];
            end

            ussd_cell u_cell (
                .clk        (clk),
                .load       (ctrl.load),
                .step       (ctrl.step),
                .op_a       (op_a[gi]),
                .op_d       (op_d[gi]),
                .r_in       (r_in),
                .a_in       (a_in),
                .borrow_in  (borrow[gi]),
                .fits       (fits),
                .r_bit      (r_vec[gi]),
                .a_bit      (a_vec[gi]),
                .borrow_out (borrow[gi+1])
            );
        end
    endgenerate

    // zero divisor flag travels beside the row
    assign zero_next = ctrl.load ? (op_d == '0) : zero_reg;
    assign dz_next   = ctrl.capture ? zero_reg : dz_reg;

    // output register
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dz_reg   <= dz_next;
        zero_reg <= zero_next;
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = quot_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire
